// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the pulse median decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property with a reset that disables it.
`define RCPMD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked property that is also watched through reset.
`define RCPMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RCPMD_ASSERT(lbl, clk, rst, prop, msg)
`define RCPMD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/rcpmd_pkg.sv =====
// Package with the register map, reset values and shared types of the pulse median decoder.
package rcpmd_pkg;

   localparam int WIDTH_W    = 16;
   localparam int TIME_W     = 32;
   localparam int TIMEOUT_W  = 24;
   localparam int GAP_W      = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_NEUTRAL_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WIDTH      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_TIMEOUT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LOW_BOUND  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_HIGH_BOUND = 3'd5;

   localparam logic [WIDTH_W-1:0]   RST_NEUTRAL_WIDTH  = 16'd1500;
   localparam logic [WIDTH_W-1:0]   RST_MIN_WIDTH      = 16'd500;
   localparam logic [WIDTH_W-1:0]   RST_MAX_WIDTH      = 16'd2500;
   localparam logic [TIMEOUT_W-1:0] RST_LOST_TIMEOUT   = 24'd100000;
   localparam logic [GAP_W-1:0]     RST_GAP_LOW_BOUND  = 20'd10000;
   localparam logic [GAP_W-1:0]     RST_GAP_HIGH_BOUND = 20'd40000;

   // Value held by every ring entry after reset.
   localparam logic [WIDTH_W-1:0]   RST_SAMPLE_WIDTH   = 16'd1500;

   typedef struct packed {
      logic [WIDTH_W-1:0]   neutral_width;
      logic [WIDTH_W-1:0]   min_width;
      logic [WIDTH_W-1:0]   max_width;
      logic [TIMEOUT_W-1:0] lost_timeout;
      logic [GAP_W-1:0]     gap_low_bound;
      logic [GAP_W-1:0]     gap_high_bound;
   } cfg_type;

endpackage

// ===== rtl/rcpmd_update.sv =====
// Edge detection, gap check, timing state and sample ring of the pulse median decoder.
module rcpmd_update #(
   parameter int RING_SIZE = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic                         level,
   input  logic [rcpmd_pkg::TIME_W-1:0] time_now,
   input  rcpmd_pkg::cfg_type           cfg,
   output logic [rcpmd_pkg::WIDTH_W-1:0] ring_next [RING_SIZE],
   output logic                         lost
);

   localparam int SLOT_W = $clog2(RING_SIZE);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SIZE - 1);

   logic                          prev_level_ff, prev_level_in;
   logic [rcpmd_pkg::TIME_W-1:0]  start_ff, start_in;
   logic [rcpmd_pkg::TIME_W-1:0]  end_ff, end_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;
   logic [rcpmd_pkg::WIDTH_W-1:0] ring_ff [RING_SIZE];

   logic                          level_change;
   logic                          rise;
   logic                          fall;
   logic                          take;
   logic [rcpmd_pkg::TIME_W-1:0]  gap_time;
   logic [rcpmd_pkg::TIME_W-1:0]  duration;
   logic [rcpmd_pkg::TIME_W-1:0]  since_start;
   logic [rcpmd_pkg::WIDTH_W-1:0] sat_width;

   always_comb begin
      level_change = fire && (level != prev_level_ff);
      rise         = level_change && level;
      fall         = level_change && !level;
      gap_time     = time_now - end_ff;
      take         = rise
                     && (gap_time > {12'd0, cfg.gap_low_bound})
                     && (gap_time < {12'd0, cfg.gap_high_bound});
      duration     = end_ff - start_ff;
      sat_width    = (|duration[31:16]) ? 16'hFFFF : duration[15:0];
      since_start  = time_now - start_ff;
      // A fresh start sets the elapsed time to zero, which never exceeds the timeout.
      lost         = !take && (since_start > {8'd0, cfg.lost_timeout});

      prev_level_in = fire ? level : prev_level_ff;
      start_in      = take ? time_now : start_ff;
      end_in        = fall ? time_now : end_ff;
      if (take) begin
         slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
      end else begin
         slot_in = slot_ff;
      end
      for (int i = 0; i < RING_SIZE; i++) begin
         ring_next[i] = (take && (slot_ff == SLOT_W'(i))) ? sat_width : ring_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         start_ff      <= '0;
         end_ff        <= '0;
         slot_ff       <= '0;
         for (int i = 0; i < RING_SIZE; i++) begin
            ring_ff[i] <= rcpmd_pkg::RST_SAMPLE_WIDTH;
         end
      end else begin
         prev_level_ff <= prev_level_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         slot_ff       <= slot_in;
         for (int i = 0; i < RING_SIZE; i++) begin
            ring_ff[i] <= ring_next[i];
         end
      end
   end

endmodule

// ===== rtl/rcpmd_median.sv =====
// Rank-based median selection and limit clamp of the pulse median decoder.
module rcpmd_median #(
   parameter int RING_SIZE = 5
) (
   input  logic [rcpmd_pkg::WIDTH_W-1:0] ring [RING_SIZE],
   input  logic                          lost,
   input  rcpmd_pkg::cfg_type            cfg,
   output logic [rcpmd_pkg::WIDTH_W-1:0] pulse_width
);

   localparam int RANK_W = $clog2(RING_SIZE);
   localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(RING_SIZE / 2);

   logic [RANK_W-1:0]             rank [RING_SIZE];
   logic [rcpmd_pkg::WIDTH_W-1:0] median;

   // Ties are broken by position, so every entry gets a distinct rank and
   // exactly one of them sits at the middle rank.
   always_comb begin
      median = '0;
      for (int i = 0; i < RING_SIZE; i++) begin
         rank[i] = '0;
         for (int j = 0; j < RING_SIZE; j++) begin
            if (j != i) begin
               if ((ring[j] < ring[i]) || ((ring[j] == ring[i]) && (j < i))) begin
                  rank[i] = rank[i] + RANK_W'(1);
               end
            end
         end
         if (rank[i] == MID_RANK) begin
            median = median | ring[i];
         end
      end

      if (lost) begin
         pulse_width = cfg.neutral_width;
      end else if (median < cfg.min_width) begin
         pulse_width = cfg.min_width;
      end else if (median > cfg.max_width) begin
         pulse_width = cfg.max_width;
      end else begin
         pulse_width = median;
      end
   end

endmodule

// ===== rtl/rc_pwm_pulse_median_decoder_core.sv =====
// Top level of the RC pulse-width decoder with median filter and signal-loss detection.
//
// Usage. Each req transaction carries one sample of a receiver pin: the pin
// level and a free-running microsecond timestamp. Every sample gives exactly
// one rsp transaction: the median of the last RING_SIZE accepted pulse widths,
// clamped to the min and max limits, or the neutral width with tuser set when
// no valid pulse start has been seen within the loss timeout.
// The csr channel writes the six limit registers; it is always ready and is
// meant to be used only while no transaction is in flight.
// Pipeline: a sample accepted into the input register passes the update stage
// and the result register before it is presented on rsp. Throughput is one
// sample per cycle while rsp is not stalled; the timing state and the ring
// update together for each sample, so no sample waits for the one before it.
// When the receiver stalls, the result register holds and the update stage and
// input register fill behind it, so req_tready falls only once all three
// stages hold a transaction.
// Reset clears the pipeline, restores the register defaults, zeroes the pulse
// timing and fills the ring with 1500 us.
`include "assert_macros.svh"

module rc_pwm_pulse_median_decoder_core #(
   parameter int RING_SIZE = 5
) (
   input  logic        clock,
   input  logic        reset,
   // Sample channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [0] pin_level, [32:1] time_now, [39:33] zero
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] pulse_width
   output logic        rsp_tuser,   // [0] signal_lost
   // Register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [rcpmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcpmd_pkg::CSR_DATA_W-1:0] csr_data
);

   rcpmd_pkg::cfg_type cfg_ff, cfg_in;

   // Input register.
   logic                          s0_valid_ff, s0_valid_in;
   logic                          s0_level_ff, s0_level_in;
   logic [rcpmd_pkg::TIME_W-1:0]  s0_time_ff, s0_time_in;
   // Update stage output register.
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_lost_ff, s1_lost_in;
   logic [rcpmd_pkg::WIDTH_W-1:0] s1_ring_ff [RING_SIZE];
   logic [rcpmd_pkg::WIDTH_W-1:0] s1_ring_in [RING_SIZE];
   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rcpmd_pkg::WIDTH_W-1:0] rsp_width_ff, rsp_width_in;
   logic                          rsp_lost_ff, rsp_lost_in;

   logic                          out_ready;
   logic                          s1_ready;
   logic                          s0_fire;
   logic [rcpmd_pkg::WIDTH_W-1:0] ring_next [RING_SIZE];
   logic                          lost_next;
   logic [rcpmd_pkg::WIDTH_W-1:0] width_next;

   // Each stage takes a new transaction when it is empty or its own one moves on.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || out_ready;
   assign req_tready = !s0_valid_ff || s1_ready;
   assign s0_fire    = s0_valid_ff && s1_ready;

   assign csr_ready  = 1'b1;

   rcpmd_update #(
      .RING_SIZE (RING_SIZE)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .fire      (s0_fire),
      .level     (s0_level_ff),
      .time_now  (s0_time_ff),
      .cfg       (cfg_ff),
      .ring_next (ring_next),
      .lost      (lost_next)
   );

   rcpmd_median #(
      .RING_SIZE (RING_SIZE)
   ) u_median (
      .ring        (s1_ring_ff),
      .lost        (s1_lost_ff),
      .cfg         (cfg_ff),
      .pulse_width (width_next)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rcpmd_pkg::CSR_NEUTRAL_WIDTH:  cfg_in.neutral_width  = csr_data[15:0];
            rcpmd_pkg::CSR_MIN_WIDTH:      cfg_in.min_width      = csr_data[15:0];
            rcpmd_pkg::CSR_MAX_WIDTH:      cfg_in.max_width      = csr_data[15:0];
            rcpmd_pkg::CSR_LOST_TIMEOUT:   cfg_in.lost_timeout   = csr_data[23:0];
            rcpmd_pkg::CSR_GAP_LOW_BOUND:  cfg_in.gap_low_bound  = csr_data[19:0];
            rcpmd_pkg::CSR_GAP_HIGH_BOUND: cfg_in.gap_high_bound = csr_data[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // Input register.
      s0_valid_in = s0_valid_ff;
      s0_level_in = s0_level_ff;
      s0_time_in  = s0_time_ff;
      if (req_tready) begin
         s0_valid_in = req_tvalid;
         s0_level_in = req_tdata[0];
         s0_time_in  = req_tdata[32:1];
      end

      // Update stage: the ring copy is the ring as left by this sample.
      s1_valid_in = s1_valid_ff;
      s1_lost_in  = s1_lost_ff;
      s1_ring_in  = s1_ring_ff;
      if (s1_ready) begin
         s1_valid_in = s0_valid_ff;
      end
      if (s0_fire) begin
         s1_lost_in = lost_next;
         s1_ring_in = ring_next;
      end

      // Result register.
      rsp_valid_in = rsp_valid_ff;
      rsp_width_in = rsp_width_ff;
      rsp_lost_in  = rsp_lost_ff;
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_width_in = width_next;
            rsp_lost_in  = s1_lost_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neutral_width  <= rcpmd_pkg::RST_NEUTRAL_WIDTH;
         cfg_ff.min_width      <= rcpmd_pkg::RST_MIN_WIDTH;
         cfg_ff.max_width      <= rcpmd_pkg::RST_MAX_WIDTH;
         cfg_ff.lost_timeout   <= rcpmd_pkg::RST_LOST_TIMEOUT;
         cfg_ff.gap_low_bound  <= rcpmd_pkg::RST_GAP_LOW_BOUND;
         cfg_ff.gap_high_bound <= rcpmd_pkg::RST_GAP_HIGH_BOUND;
         s0_valid_ff           <= 1'b0;
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s0_level_ff  <= s0_level_in;
      s0_time_ff   <= s0_time_in;
      s1_lost_ff   <= s1_lost_in;
      s1_ring_ff   <= s1_ring_in;
      rsp_width_ff <= rsp_width_in;
      rsp_lost_ff  <= rsp_lost_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_width_ff;
   assign rsp_tuser  = rsp_lost_ff;

   // A sample that leaves the input register must reach the update stage register.
   `RCPMD_ASSERT(a_s0_moves_on, clock, reset, (s0_valid_ff && s1_ready) |=> s1_valid_ff, "input stage transaction lost")
   // The sample channel only stalls when every stage holds a transaction.
   `RCPMD_ASSERT(a_stall_only_full, clock, reset, !req_tready |-> (s0_valid_ff && s1_valid_ff && rsp_valid_ff), "sample channel stalled with a free stage")
   // A blocked update stage keeps its transaction.
   `RCPMD_ASSERT(a_s1_holds, clock, reset, (s1_valid_ff && !s1_ready) |=> s1_valid_ff, "update stage dropped a stalled transaction")

endmodule

// ===== tb/rc_pwm_pulse_median_decoder_core_tb.sv =====
// Testbench for the RC pulse median decoder: stimulus, result predictor and scoreboard.
module rc_pwm_pulse_median_decoder_core_tb;

   localparam int RING        = 5;
   localparam int CYCLE_LIMIT = 400000;
   // Receiver hold-off used to back the pipeline up into the sample channel.
   localparam int HOLD_CYCLES = 300;

   // One expected result: the reported width and the lost flag.
   typedef struct packed {
      logic [rcpmd_pkg::WIDTH_W-1:0] pulse_width;
      logic                          signal_lost;
   } width_result_type;

   typedef logic [rcpmd_pkg::CSR_DATA_W-1:0] csr_word_type;
   typedef bit [rcpmd_pkg::TIME_W-1:0]       stamp_type;

   // The scoreboard keeps its own copy of the limit registers and of the pulse
   // timing state, predicts the result of every accepted sample and compares
   // the results of the block against those predictions in order.
   class median_scoreboard;
      logic [rcpmd_pkg::WIDTH_W-1:0]   neutral;
      logic [rcpmd_pkg::WIDTH_W-1:0]   min_w;
      logic [rcpmd_pkg::WIDTH_W-1:0]   max_w;
      logic [rcpmd_pkg::TIMEOUT_W-1:0] timeout;
      logic [rcpmd_pkg::GAP_W-1:0]     gap_lo;
      logic [rcpmd_pkg::GAP_W-1:0]     gap_hi;

      bit                              prev_level;
      bit [rcpmd_pkg::TIME_W-1:0]      start_t;
      bit [rcpmd_pkg::TIME_W-1:0]      end_t;
      int                              slot;
      bit [rcpmd_pkg::WIDTH_W-1:0]     ring[RING];

      width_result_type                expected_widths[$];
      int                              errors;
      int                              checked;
      int                              lost_seen;
      int                              pulses_stored;
      int                              saturated;
      int                              clamped;

      function new();
         neutral       = rcpmd_pkg::RST_NEUTRAL_WIDTH;
         min_w         = rcpmd_pkg::RST_MIN_WIDTH;
         max_w         = rcpmd_pkg::RST_MAX_WIDTH;
         timeout       = rcpmd_pkg::RST_LOST_TIMEOUT;
         gap_lo        = rcpmd_pkg::RST_GAP_LOW_BOUND;
         gap_hi        = rcpmd_pkg::RST_GAP_HIGH_BOUND;
         prev_level    = 1'b0;
         start_t       = '0;
         end_t         = '0;
         slot          = 0;
         foreach (ring[i]) ring[i] = rcpmd_pkg::RST_SAMPLE_WIDTH;
         errors        = 0;
         checked       = 0;
         lost_seen     = 0;
         pulses_stored = 0;
         saturated     = 0;
         clamped       = 0;
      endfunction

      function void write_reg(logic [rcpmd_pkg::CSR_IDX_W-1:0] idx,
                              logic [rcpmd_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            rcpmd_pkg::CSR_NEUTRAL_WIDTH:  neutral = data[rcpmd_pkg::WIDTH_W-1:0];
            rcpmd_pkg::CSR_MIN_WIDTH:      min_w   = data[rcpmd_pkg::WIDTH_W-1:0];
            rcpmd_pkg::CSR_MAX_WIDTH:      max_w   = data[rcpmd_pkg::WIDTH_W-1:0];
            rcpmd_pkg::CSR_LOST_TIMEOUT:   timeout = data[rcpmd_pkg::TIMEOUT_W-1:0];
            rcpmd_pkg::CSR_GAP_LOW_BOUND:  gap_lo  = data[rcpmd_pkg::GAP_W-1:0];
            rcpmd_pkg::CSR_GAP_HIGH_BOUND: gap_hi  = data[rcpmd_pkg::GAP_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_widths.size();
      endfunction

      // Advances the pulse timing for one sample and queues the width it reports.
      function void note_sample(bit lvl, bit [rcpmd_pkg::TIME_W-1:0] now);
         bit [rcpmd_pkg::TIME_W-1:0]  low_t;
         bit [rcpmd_pkg::TIME_W-1:0]  span;
         bit [rcpmd_pkg::TIME_W-1:0]  elapsed;
         bit [rcpmd_pkg::WIDTH_W-1:0] sorted[RING];
         bit [rcpmd_pkg::WIDTH_W-1:0] v;
         int                          j;
         width_result_type            r;

         if (lvl != prev_level) begin
            if (lvl) begin
               low_t = now - end_t;
               if (low_t > gap_lo && low_t < gap_hi) begin
                  span = end_t - start_t;
                  if (span > 32'h0000_FFFF) begin
                     ring[slot] = 16'hFFFF;
                     saturated++;
                  end else begin
                     ring[slot] = span[rcpmd_pkg::WIDTH_W-1:0];
                  end
                  slot    = (slot + 1) % RING;
                  start_t = now;
                  pulses_stored++;
               end
            end else begin
               end_t = now;
            end
            prev_level = lvl;
         end

         elapsed = now - start_t;
         if (elapsed > {8'd0, timeout}) begin
            r.pulse_width = neutral;
            r.signal_lost = 1'b1;
         end else begin
            sorted = ring;
            for (int i = 1; i < RING; i++) begin
               v = sorted[i];
               j = i;
               while (j > 0 && sorted[j-1] > v) begin
                  sorted[j] = sorted[j-1];
                  j--;
               end
               sorted[j] = v;
            end
            r.pulse_width = sorted[RING/2];
            r.signal_lost = 1'b0;
            // With crossed limits, a median below the minimum gives the minimum and any other the maximum.
            if (r.pulse_width < min_w) begin
               r.pulse_width = min_w;
               clamped++;
            end else if (r.pulse_width > max_w) begin
               r.pulse_width = max_w;
               clamped++;
            end
         end
         expected_widths.push_back(r);
      endfunction

      function void check_width(logic [rcpmd_pkg::WIDTH_W-1:0] width, logic lost);
         width_result_type e;
         if (expected_widths.size() == 0) begin
            $display("%0t: result with nothing expected: width %0d lost %0b",
                     $time, width, lost);
            errors++;
            return;
         end
         e = expected_widths.pop_front();
         checked++;
         if (lost) lost_seen++;
         if (width !== e.pulse_width) begin
            $display("%0t: pulse_width mismatch: expected %0d, actual %0d",
                     $time, e.pulse_width, width);
            errors++;
         end
         if (lost !== e.signal_lost) begin
            $display("%0t: signal_lost mismatch: expected %0b, actual %0b",
                     $time, e.signal_lost, lost);
            errors++;
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [39:0]                         req_tdata;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [15:0]                         rsp_tdata;
   logic                                rsp_tuser;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [rcpmd_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [rcpmd_pkg::CSR_DATA_W-1:0]    csr_data;

   median_scoreboard sb;

   // Stimulus bookkeeping: current pin level and timestamp as last sent.
   bit [rcpmd_pkg::TIME_W-1:0] now_us;
   bit                         pin_now;
   int                         items_sent;
   int                         phases_run;
   int                         input_stall_cycles;
   int                         cycle_count;

   // Handshake shaping shared by the sender and the receiver processes.
   bit              no_gaps;
   bit              hold_request;

   rc_pwm_pulse_median_decoder_core #(
      .RING_SIZE (RING)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Result monitor: every transaction on the result channel is checked against
   // the oldest prediction. It also counts the cycles in which the sample
   // channel was held off, which shows that back-pressure reached the input.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_width(rsp_tdata, rsp_tuser);
      if (!reset && req_tvalid && !req_tready) input_stall_cycles++;
   end

   // Watchdog. The limit is several times the slowest legal run: every sample
   // waiting out the longest sender gap and the longest receiver stall.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver. Ready is decided once per falling edge. Most cycles it accepts,
   // sometimes it stalls briefly and now and then for a long stretch. When the
   // main process asks for a hold-off, ready stays low through it, counted
   // down here, so that the pipeline fills and the sample channel stalls.
   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (no_gaps) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(15, 40);
            end
         end
      end
   end

   // Offers one sample and waits for its transaction. The valid line is left
   // high afterwards so that back-to-back samples need no second assignment.
   task automatic push_sample(input bit lvl, input bit [rcpmd_pkg::TIME_W-1:0] t);
      int gap;
      int r;
      r   = $urandom_range(0, 99);
      gap = 0;
      if (!no_gaps) begin
         if (r >= 95)      gap = $urandom_range(10, 30);
         else if (r >= 55) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, t, lvl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(lvl, t);
      items_sent++;
      pin_now = lvl;
      now_us  = t;
      @(negedge clock);
   endtask

   task automatic step(input bit lvl, input bit [rcpmd_pkg::TIME_W-1:0] dt);
      push_sample(lvl, now_us + dt);
   endtask

   // Drops valid and waits for the next falling edge so that a following
   // transaction can raise it again without two assignments in one time step.
   task automatic idle_sender();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [rcpmd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rcpmd_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Waits for the pipeline to empty, then rewrites all six limit registers.
   task automatic set_limits(input int neutral, input int min_w, input int max_w,
                             input int timeout, input int gap_lo, input int gap_hi);
      idle_sender();
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_csr(rcpmd_pkg::CSR_NEUTRAL_WIDTH,  csr_word_type'(neutral));
      write_csr(rcpmd_pkg::CSR_MIN_WIDTH,      csr_word_type'(min_w));
      write_csr(rcpmd_pkg::CSR_MAX_WIDTH,      csr_word_type'(max_w));
      write_csr(rcpmd_pkg::CSR_LOST_TIMEOUT,   csr_word_type'(timeout));
      write_csr(rcpmd_pkg::CSR_GAP_LOW_BOUND,  csr_word_type'(gap_lo));
      write_csr(rcpmd_pkg::CSR_GAP_HIGH_BOUND, csr_word_type'(gap_hi));
      phases_run++;
   endtask

   // One receiver frame: a low gap followed by a high pulse. A well-formed frame
   // has its gap strictly inside the current window, or a random gap when the
   // window holds no value; a broken one sits on a bound, outside it or near zero.
   // Either phase may carry a repeated sample of the same level in the middle.
   task automatic send_frame(input bit broken);
      bit [rcpmd_pkg::TIME_W-1:0] low_t;
      bit [rcpmd_pkg::TIME_W-1:0] high_t;
      if (broken) begin
         case ($urandom_range(0, 4))
            0:       low_t = stamp_type'(sb.gap_lo);
            1:       low_t = stamp_type'(sb.gap_hi);
            2:       low_t = sb.gap_lo - $urandom_range(1, 500);
            3:       low_t = sb.gap_hi + $urandom_range(1, 5000);
            default: low_t = $urandom_range(0, 3);
         endcase
      end else if (sb.gap_hi > sb.gap_lo + 1) begin
         low_t = $urandom_range(sb.gap_lo + 1, sb.gap_hi - 1);
      end else begin
         low_t = $urandom_range(0, 50000);
      end
      high_t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80000)
                                           : $urandom_range(900, 2100);
      if (pin_now) step(1'b0, $urandom_range(500, 2500));
      if ($urandom_range(0, 2) == 0) begin
         step(1'b0, low_t / 2);
         step(1'b1, low_t - low_t / 2);
      end else begin
         step(1'b1, low_t);
      end
      if ($urandom_range(0, 2) == 0) begin
         step(1'b1, high_t / 2);
         step(1'b0, high_t - high_t / 2);
      end else begin
         step(1'b0, high_t);
      end
   endtask

   // Random part: mostly well-formed frames, with broken frames, noise samples at
   // arbitrary times and samples placed on the loss timeout or one microsecond past it.
   task automatic run_random(input int count);
      int target;
      int r;
      target = items_sent + count;
      while (items_sent < target) begin
         r = $urandom_range(0, 9);
         if (r < 7) begin
            send_frame(1'b0);
         end else if (r == 7) begin
            send_frame(1'b1);
         end else if (r == 8) begin
            if ($urandom_range(0, 1)) step(1'($urandom_range(0, 1)), $urandom_range(0, 3000));
            else push_sample(1'($urandom_range(0, 1)), $urandom());
         end else begin
            push_sample(pin_now, sb.start_t + sb.timeout + $urandom_range(0, 1));
         end
      end
   endtask

   initial begin
      int leftover;
      sb                 = new();
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      csr_valid          = 1'b0;
      csr_index          = rcpmd_pkg::CSR_NEUTRAL_WIDTH;
      csr_data           = '0;
      now_us             = '0;
      pin_now            = 1'b0;
      items_sent         = 0;
      phases_run         = 0;
      input_stall_cycles = 0;
      cycle_count        = 0;
      no_gaps            = 1'b0;
      hold_request       = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed samples at the reset limits. The first one repeats the reset
      // level, then two pulses are measured with gaps well inside the window.
      push_sample(1'b0, 32'd0);
      push_sample(1'b1, 32'd20000);
      push_sample(1'b1, 32'd20500);
      push_sample(1'b0, 32'd21000);
      push_sample(1'b1, 32'd41000);
      push_sample(1'b0, 32'd43100);
      // Gaps exactly on the lower and on the upper bound are rejected.
      push_sample(1'b1, 32'd53100);
      push_sample(1'b0, 32'd53200);
      push_sample(1'b1, 32'd93200);
      push_sample(1'b0, 32'd93300);
      // Gaps one inside each bound are accepted.
      push_sample(1'b1, 32'd103301);
      push_sample(1'b0, 32'd103400);
      push_sample(1'b1, 32'd143399);
      // Exactly on the timeout the signal is still held; one later it is lost.
      push_sample(1'b1, 32'd243399);
      push_sample(1'b1, 32'd243400);
      // A pulse of over 65535 us is stored saturated.
      push_sample(1'b0, 32'd243500);
      push_sample(1'b1, 32'd263500);
      // Timestamps wrapping through zero, then the all-ones timestamp.
      push_sample(1'b0, 32'hFFFF_F000);
      push_sample(1'b1, 32'h0000_3000);
      push_sample(1'b0, 32'h0000_3000 + 32'd1700);
      push_sample(1'b1, 32'h0000_3000 + 32'd16700);
      push_sample(1'b0, 32'h0000_3000 + 32'd18200);
      push_sample(1'b1, 32'hFFFF_FFFF);
      push_sample(1'b0, 32'hFFFF_FFFF);
      run_random(110);

      // Widest limits: no clamping, longest timeout, the whole gap range open.
      set_limits(65535, 0, 65535, 16777215, 0, 1048575);
      run_random(110);

      // Crossed clamp limits, zero timeout and an empty gap window.
      set_limits(0, 2000, 1000, 0, 1048575, 0);
      run_random(60);

      // Mid-range limits. Here the receiver holds off for a long stretch while
      // samples keep coming, then both sides run without idling for a while.
      set_limits($urandom_range(0, 65535), 1000, 2000, 60000, 5000, 30000);
      run_random(40);
      hold_request = 1'b1;
      no_gaps      = 1'b1;
      run_random(40);
      no_gaps      = 1'b0;
      run_random(40);

      // Random limits, possibly crossed, with a window of at least one value.
      begin
         int lo;
         lo = $urandom_range(0, 20000);
         set_limits($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(20000, 16777215),
                    lo, lo + $urandom_range(2, 30000));
      end
      run_random(120);

      // Both clamps at zero and a gap window of only one and two microseconds.
      set_limits($urandom_range(0, 65535), 0, 0, 16777215, 0, 3);
      run_random(110);

      idle_sender();
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      leftover = sb.pending();
      if (leftover != 0) begin
         $display("%0t: %0d expected results never arrived", $time, leftover);
         sb.errors += leftover;
      end

      $display("Sent %0d samples over %0d limit settings; %0d results checked, %0d lost.",
               items_sent, phases_run + 1, sb.checked, sb.lost_seen);
      $display("Pulses stored %0d (%0d saturated), clamped %0d, input stalled %0d cycles.",
               sb.pulses_stored, sb.saturated, sb.clamped, input_stall_cycles);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rcpmd_pkg.sv
rtl/rcpmd_update.sv
rtl/rcpmd_median.sv
rtl/rc_pwm_pulse_median_decoder_core.sv
tb/rc_pwm_pulse_median_decoder_core_tb.sv
